// ===== hdl/lrec_pkg.sv =====
// Shared widths, register indexes and edge codes for the line and rectangle edge crossing unit.
package lrec_pkg;

  localparam int DIR_W  = 16;
  localparam int PT_W   = 24;
  localparam int COORD_W = 16;
  localparam int SIZE_W = 15;
  localparam int TOL_W  = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic signed [PT_W-1:0] OUT_MAX = 24'sh7FFFFF;
  localparam logic signed [PT_W-1:0] OUT_MIN = -24'sh800000;

  typedef enum logic [1:0] {
    EDGE_LEFT   = 2'd0,
    EDGE_TOP    = 2'd1,
    EDGE_RIGHT  = 2'd2,
    EDGE_BOTTOM = 2'd3
  } edge_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT   = 3'd0,
    REG_TOP    = 3'd1,
    REG_WIDTH  = 3'd2,
    REG_HEIGHT = 3'd3,
    REG_TOL    = 3'd4
  } cfg_reg_t;

endpackage

// ===== hdl/line_rect_edge_crossing_unit.sv =====
// Top level: crosses a line with the left, top, right and bottom edges of a rectangle window.
//
// A new line can be accepted while earlier lines are still in the pipeline;
// busy is high after an accepted start and drops when the sequencer issues
// the bottom edge. Each line gives a beat per edge, left, top, right and bottom,
// on out_valid in consecutive cycles. The single result port limits how often
// a line can be accepted; most of the pipeline depth comes from a pipelined
// restoring divider that resolves one quotient bit per stage. Results cannot be stalled:
// take each beat when out_valid is high. Write the window registers only while
// no line is in flight.
module line_rect_edge_crossing_unit #(
  parameter int FRAC_BITS = 8
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [lrec_pkg::DIR_W-1:0]      in_line_dir_x,
  input  logic signed [lrec_pkg::DIR_W-1:0]      in_line_dir_y,
  input  logic signed [lrec_pkg::PT_W-1:0]       in_line_point_x,
  input  logic signed [lrec_pkg::PT_W-1:0]       in_line_point_y,
  input  logic                                   cfg_we,
  input  logic [lrec_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [lrec_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  output logic                                   out_valid,
  output logic [1:0]                             out_edge_index,
  output logic                                   out_is_hit,
  output logic signed [lrec_pkg::PT_W-1:0]       out_cross_x,
  output logic signed [lrec_pkg::PT_W-1:0]       out_cross_y,
  output logic                                   out_is_last
);
  import lrec_pkg::*;

  localparam int EW  = 18 + FRAC_BITS;
  localparam int DW  = ((EW > PT_W) ? EW : PT_W) + 1;
  localparam int PW  = DW + DIR_W;
  localparam int QB  = DW + 1;
  localparam int NNW = PW + 2;
  localparam int RW  = DIR_W + 1;
  localparam int VW  = QB + 2;
  localparam int TW  = TOL_W + FRAC_BITS;

  typedef struct packed {
    logic [1:0]               k;
    logic signed [PT_W-1:0]   pa;
    logic signed [EW-1:0]     e;
    logic                     neg;
    logic                     ovf;
    logic                     zero;
  } meta_t;

  // configuration
  logic signed [COORD_W-1:0] left_r, top_r;
  logic [SIZE_W-1:0]         width_r, height_r;
  logic [TOL_W-1:0]          tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= '0;
      top_r    <= '0;
      width_r  <= SIZE_W'(1);
      height_r <= SIZE_W'(1);
      tol_r    <= TOL_W'(26);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEFT:   left_r   <= cfg_wdata;
        REG_TOP:    top_r    <= cfg_wdata;
        REG_WIDTH:  width_r  <= cfg_wdata[SIZE_W-1:0];
        REG_HEIGHT: height_r <= cfg_wdata[SIZE_W-1:0];
        REG_TOL:    tol_r    <= cfg_wdata[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  logic signed [EW-1:0] lft, top, rgt, bot;
  logic signed [TW-1:0] tol_s;
  always_comb begin
    lft = EW'(left_r) <<< FRAC_BITS;
    top = EW'(top_r) <<< FRAC_BITS;
    rgt = (EW'(left_r) + EW'($signed({1'b0, width_r})) - EW'(1)) <<< FRAC_BITS;
    bot = (EW'(top_r) + EW'($signed({1'b0, height_r})) - EW'(1)) <<< FRAC_BITS;
    tol_s = $signed({tol_r, {FRAC_BITS{1'b0}}} >> TOL_W);
  end

  // issue sequencer
  logic                       act_r;
  logic [1:0]                 cnt_r;
  logic signed [DIR_W-1:0]    dx_r, dy_r;
  logic signed [PT_W-1:0]     px_r, py_r;
  logic                       accept;

  assign busy   = act_r && (cnt_r != 2'd3);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      cnt_r <= '0;
    end else if (accept) begin
      act_r <= 1'b1;
      cnt_r <= '0;
    end else if (act_r) begin
      cnt_r <= cnt_r + 2'd1;
      if (cnt_r == 2'd3) act_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dx_r <= in_line_dir_x;
      dy_r <= in_line_dir_y;
      px_r <= in_line_point_x;
      py_r <= in_line_point_y;
    end
  end

  // stage 1: edge select and offset
  logic                     s1_v_r;
  logic [1:0]               s1_k_r;
  logic signed [DW-1:0]     s1_diff_r;
  logic signed [DIR_W-1:0]  s1_da_r, s1_dc_r;
  logic signed [PT_W-1:0]   s1_pa_r;
  logic signed [EW-1:0]     s1_e_r;

  logic signed [EW-1:0]     e_nxt;
  logic signed [PT_W-1:0]   pc_nxt, pa_nxt;
  logic signed [DIR_W-1:0]  dc_nxt, da_nxt;
  always_comb begin
    unique case (edge_t'(cnt_r))
      EDGE_LEFT:   e_nxt = lft;
      EDGE_TOP:    e_nxt = top;
      EDGE_RIGHT:  e_nxt = rgt;
      EDGE_BOTTOM: e_nxt = bot;
      default:     e_nxt = lft;
    endcase
    if (cnt_r[0]) begin
      pc_nxt = py_r; dc_nxt = dy_r; pa_nxt = px_r; da_nxt = dx_r;
    end else begin
      pc_nxt = px_r; dc_nxt = dx_r; pa_nxt = py_r; da_nxt = dy_r;
    end
  end

  // stage 2: product
  logic                     s2_v_r;
  logic signed [PW-1:0]     s2_prod_r;
  logic signed [DIR_W-1:0]  s2_dc_r;
  logic [1:0]               s2_k_r;
  logic signed [PT_W-1:0]   s2_pa_r;
  logic signed [EW-1:0]     s2_e_r;

  // divider stages
  logic             d_v_r   [0:QB];
  meta_t            d_m_r   [0:QB];
  logic [NNW-1:0]   d_n_r   [0:QB];
  logic [RW-1:0]    d_d_r   [0:QB];
  logic [RW-1:0]    d_rem_r [0:QB];
  logic [QB-1:0]    d_q_r   [0:QB];

  logic [PW-1:0]    an;
  logic [DIR_W-1:0] ad;
  logic [NNW-1:0]   n_nxt;
  logic [RW-1:0]    den_nxt;
  always_comb begin
    an      = s2_prod_r[PW-1] ? PW'(-s2_prod_r) : PW'(s2_prod_r);
    ad      = s2_dc_r[DIR_W-1] ? DIR_W'(-s2_dc_r) : DIR_W'(s2_dc_r);
    n_nxt   = (NNW'(an) << 1) + NNW'(ad);
    den_nxt = {ad, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      d_v_r[0] <= 1'b0;
    end else begin
      s1_v_r <= act_r;
      s2_v_r <= s1_v_r;
      d_v_r[0] <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_k_r    <= cnt_r;
    s1_diff_r <= DW'(e_nxt) - DW'(pc_nxt);
    s1_da_r   <= da_nxt;
    s1_dc_r   <= dc_nxt;
    s1_pa_r   <= pa_nxt;
    s1_e_r    <= e_nxt;

    s2_prod_r <= PW'(s1_diff_r) * PW'(s1_da_r);
    s2_dc_r   <= s1_dc_r;
    s2_k_r    <= s1_k_r;
    s2_pa_r   <= s1_pa_r;
    s2_e_r    <= s1_e_r;

    d_m_r[0].k    <= s2_k_r;
    d_m_r[0].pa   <= s2_pa_r;
    d_m_r[0].e    <= s2_e_r;
    d_m_r[0].neg  <= s2_prod_r[PW-1] ^ s2_dc_r[DIR_W-1];
    d_m_r[0].ovf  <= n_nxt[NNW-1:QB] >= den_nxt;
    d_m_r[0].zero <= (s2_dc_r == '0);
    d_n_r[0]      <= n_nxt;
    d_d_r[0]      <= den_nxt;
    d_rem_r[0]    <= n_nxt[NNW-1:QB];
    d_q_r[0]      <= '0;
  end

  for (genvar i = 0; i < QB; i++) begin : g_div
    logic [RW:0]   t;
    logic          ge;
    logic [RW-1:0] rem_nxt;
    always_comb begin
      t       = {d_rem_r[i], d_n_r[i][QB-1-i]};
      ge      = t >= {1'b0, d_d_r[i]};
      rem_nxt = ge ? RW'(t - {1'b0, d_d_r[i]}) : t[RW-1:0];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) d_v_r[i+1] <= 1'b0;
      else        d_v_r[i+1] <= d_v_r[i];
    end
    always_ff @(posedge clk) begin
      d_m_r[i+1]   <= d_m_r[i];
      d_n_r[i+1]   <= d_n_r[i];
      d_d_r[i+1]   <= d_d_r[i];
      d_rem_r[i+1] <= rem_nxt;
      d_q_r[i+1]   <= {d_q_r[i][QB-2:0], ge};
    end
  end

  // final stage: crossing, span test, saturation
  function automatic logic signed [PT_W-1:0] sat24(input logic signed [VW-1:0] v);
    if (v > VW'(OUT_MAX))      sat24 = OUT_MAX;
    else if (v < VW'(OUT_MIN)) sat24 = OUT_MIN;
    else                       sat24 = PT_W'(v);
  endfunction

  meta_t                  fm;
  logic [QB-1:0]          qm;
  logic signed [VW-1:0]   sq, v, lo, hi, tv;
  logic                   hit;
  logic signed [PT_W-1:0] along_s, e_s;
  always_comb begin
    fm = d_m_r[QB];
    qm = fm.ovf ? '1 : d_q_r[QB];
    sq = fm.neg ? -VW'($signed({1'b0, qm})) : VW'($signed({1'b0, qm}));
    v  = VW'(fm.pa) + sq;
    tv = VW'(tol_s);
    if (fm.k[0]) begin
      lo = VW'(lft); hi = VW'(rgt);
    end else begin
      lo = VW'(top); hi = VW'(bot);
    end
    hit     = !fm.zero && (v >= lo - tv) && (v <= hi + tv);
    along_s = sat24(v);
    e_s     = sat24(VW'(fm.e));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= d_v_r[QB];
  end

  always_ff @(posedge clk) begin
    out_edge_index <= fm.k;
    out_is_hit     <= hit;
    out_is_last    <= (edge_t'(fm.k) == EDGE_BOTTOM);
    if (!hit) begin
      out_cross_x <= '0;
      out_cross_y <= '0;
    end else if (fm.k[0]) begin
      out_cross_x <= along_s;
      out_cross_y <= e_s;
    end else begin
      out_cross_x <= e_s;
      out_cross_y <= along_s;
    end
  end

endmodule

// ===== dv/line_rect_edge_crossing_unit_tb.sv =====
// Testbench for the line and rectangle edge crossing unit: predicts a left, top, right and bottom edge beat per line.
module line_rect_edge_crossing_unit_tb;
  import lrec_pkg::*;

  localparam int FRAC_BITS = 8;
  localparam int DRAIN_CYCLES = FRAC_BITS + 60;
  localparam int STALL_LIMIT = 2000;

  typedef struct {
    logic [1:0]           edge_idx;
    logic                 hit;
    logic signed [23:0]   cx;
    logic signed [23:0]   cy;
    logic                 last;
  } crossing_t;

  class crossing_scoreboard;
    longint win_left, win_top, win_width, win_height, tol_raw;
    crossing_t pending[$];
    int errors;

    function new();
      win_left = 0; win_top = 0; win_width = 1; win_height = 1; tol_raw = 26;
      errors = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [15:0] val);
      case (idx)
        REG_LEFT:   win_left   = longint'($signed(val));
        REG_TOP:    win_top    = longint'($signed(val));
        REG_WIDTH:  win_width  = longint'(val[14:0]);
        REG_HEIGHT: win_height = longint'(val[14:0]);
        REG_TOL:    win_tol_set(val[7:0]);
        default: ;
      endcase
    endfunction

    function void win_tol_set(logic [7:0] v);
      tol_raw = longint'(v);
    endfunction

    function longint round_quot(longint num, longint den);
      longint an, ad, q;
      bit neg;
      neg = (num < 0) != (den < 0);
      an = num < 0 ? -num : num;
      ad = den < 0 ? -den : den;
      q = (2 * an + ad) / (2 * ad);
      return neg ? -q : q;
    endfunction

    function logic signed [23:0] clamp24(longint v);
      if (v > 64'sd8388607) return OUT_MAX;
      if (v < -64'sd8388608) return OUT_MIN;
      return v[23:0];
    endfunction

    function void note_line(logic signed [15:0] dxs, logic signed [15:0] dys,
                            logic signed [23:0] pxs, logic signed [23:0] pys);
      longint dx, dy, px, py, lft, top, rgt, bot, tol, e, along, lo, hi;
      longint cxv, cyv;
      crossing_t r;
      bit hit;
      dx = dxs; dy = dys; px = pxs; py = pys;
      lft = win_left <<< FRAC_BITS;
      top = win_top <<< FRAC_BITS;
      rgt = (win_left + win_width - 1) * (64'sd1 <<< FRAC_BITS);
      bot = (win_top + win_height - 1) * (64'sd1 <<< FRAC_BITS);
      tol = (tol_raw * (64'sd1 <<< FRAC_BITS)) / 256;
      for (int k = 0; k < 4; k++) begin
        hit = 0; cxv = 0; cyv = 0;
        if (k == EDGE_LEFT || k == EDGE_RIGHT) begin
          e = (k == EDGE_LEFT) ? lft : rgt;
          lo = top; hi = bot;
          if (dx != 0) begin
            along = py + round_quot((e - px) * dy, dx);
            hit = along >= lo - tol && along <= hi + tol;
            cxv = e; cyv = along;
          end
        end else begin
          e = (k == EDGE_TOP) ? top : bot;
          lo = lft; hi = rgt;
          if (dy != 0) begin
            along = px + round_quot((e - py) * dx, dy);
            hit = along >= lo - tol && along <= hi + tol;
            cxv = along; cyv = e;
          end
        end
        if (!hit) begin
          cxv = 0; cyv = 0;
        end
        r.edge_idx = k[1:0];
        r.hit = hit;
        r.cx = clamp24(cxv);
        r.cy = clamp24(cyv);
        r.last = (k == EDGE_BOTTOM);
        pending = {pending, r};
      end
    endfunction

    function void check_beat(logic [1:0] ei, logic h, logic signed [23:0] cx,
                             logic signed [23:0] cy, logic l);
      crossing_t x;
      if (pending.size() == 0) begin
        $error("unexpected beat edge_index=%0d", ei);
        errors++;
        return;
      end
      x = pending.pop_front();
      if (ei !== x.edge_idx) begin
        $error("edge_index expected %0d actual %0d", x.edge_idx, ei); errors++;
      end
      if (h !== x.hit) begin
        $error("is_hit expected %0d actual %0d", x.hit, h); errors++;
      end
      if (cx !== x.cx) begin
        $error("cross_x expected %0d actual %0d", x.cx, cx); errors++;
      end
      if (cy !== x.cy) begin
        $error("cross_y expected %0d actual %0d", x.cy, cy); errors++;
      end
      if (l !== x.last) begin
        $error("is_last expected %0d actual %0d", x.last, l); errors++;
      end
    endfunction
  endclass

  logic clk, rst_n, start, busy, cfg_we, out_valid, out_is_hit, out_is_last;
  logic signed [15:0] in_line_dir_x, in_line_dir_y;
  logic signed [23:0] in_line_point_x, in_line_point_y;
  logic [2:0] cfg_index;
  logic [15:0] cfg_wdata;
  logic [1:0] out_edge_index;
  logic signed [23:0] out_cross_x, out_cross_y;

  crossing_scoreboard sb;
  int idle_cycles;

  line_rect_edge_crossing_unit #(.FRAC_BITS(FRAC_BITS)) dut (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_beat(out_edge_index, out_is_hit, out_cross_x, out_cross_y, out_is_last);
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_cfg(cfg_reg_t idx, logic [15:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic send_line(logic [15:0] dx, logic [15:0] dy, logic [23:0] px,
                           logic [23:0] py);
    cfg_we <= 0;
    start <= 1;
    in_line_dir_x <= dx; in_line_dir_y <= dy;
    in_line_point_x <= px; in_line_point_y <= py;
    do @(posedge clk); while (busy);
    sb.note_line(dx, dy, px, py);
  endtask

  task automatic pause();
    cfg_we <= 0;
    start <= 0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  task automatic drain();
    cfg_we <= 0;
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_lines(int n);
    int burst;
    logic [15:0] dx, dy;
    logic [23:0] px, py;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        pause();
        burst = $urandom_range(1, 8);
      end
      burst--;
      case ($urandom_range(0, 5))
        0: begin dx = 16'($urandom); dy = 16'($urandom); end
        1: begin dx = 0; dy = $urandom_range(0, 1) ? 16'(16384) : 16'(-16384); end
        2: begin dy = 0; dx = $urandom_range(0, 1) ? 16'(16384) : 16'(-16384); end
        default: begin
          dx = 16'($urandom_range(0, 32768) - 16384);
          dy = 16'($urandom_range(0, 32768) - 16384);
        end
      endcase
      if ($urandom_range(0, 3) == 0) begin
        px = 24'($urandom); py = 24'($urandom);
      end else begin
        px = 24'(((sb.win_left + $urandom_range(0, 80)) <<< FRAC_BITS)
             + $urandom_range(0, 255) - 20 * 256);
        py = 24'(((sb.win_top + $urandom_range(0, 80)) <<< FRAC_BITS)
             + $urandom_range(0, 255) - 20 * 256);
      end
      send_line(dx, dy, px, py);
    end
  endtask

  initial begin
    sb = new();
    rst_n = 0; start = 0; cfg_we = 0; cfg_index = 0; cfg_wdata = 0;
    in_line_dir_x = 0; in_line_dir_y = 0; in_line_point_x = 0; in_line_point_y = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send_line(16384, 0, 0, 0);
    send_line(0, 16384, 0, 0);
    send_line(0, 0, 100, 100);
    drain();
    write_cfg(REG_LEFT, 10); write_cfg(REG_TOP, 20);
    write_cfg(REG_WIDTH, 50); write_cfg(REG_HEIGHT, 40);
    write_cfg(REG_TOL, 0);
    send_line(11585, 11585, 20 * 256, 30 * 256);
    send_line(16'(-11585), 11585, 35 * 256, 25 * 256);
    send_line(16384, 100, 0, 20 * 256 + 128);
    send_line(100, 16'(-16384), 59 * 256 + 128, 0);
    send_line(16'h7FFF, 16'h8000, 24'h7FFFFF, 24'h800000);
    send_line(16'h8000, 16'h7FFF, 24'h800000, 24'h7FFFFF);
    send_line(16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'h000001);
    send_line(1, 16384, 24'h7FFFFF, 0);
    send_line(16384, 1, 0, 24'h800000);
    send_line(16'h5555, 16'hAAAA, 24'h555555, 24'hAAAAAA);
    drain();
    write_cfg(REG_LEFT, 16'h8000); write_cfg(REG_TOP, 16'h7FFF);
    write_cfg(REG_WIDTH, 16'h7FFF); write_cfg(REG_HEIGHT, 16'h0000);
    write_cfg(REG_TOL, 255);
    write_cfg(cfg_reg_t'(3'd6), 16'h1234);
    send_line(1, 16384, 0, 0);
    send_line(16384, 1, 0, 0);
    send_line(3, 5, 24'h000100, 24'hFFFF00);
    random_lines(30);
    drain();
    write_cfg(REG_LEFT, 16'h7FFF); write_cfg(REG_TOP, 16'h8000);
    write_cfg(REG_WIDTH, 1); write_cfg(REG_HEIGHT, 16'h7FFF);
    write_cfg(REG_TOL, 26);
    random_lines(30);
    drain();
    write_cfg(REG_LEFT, 16'hFFF0); write_cfg(REG_TOP, 5);
    write_cfg(REG_WIDTH, 64); write_cfg(REG_HEIGHT, 48);
    write_cfg(REG_TOL, 128);
    random_lines(53);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
